// File: sv/imsd_pkg.sv
// Shared types and constants for the ITCH message stream decoder.
// No dependencies.
package imsd_pkg;

  localparam int LOCATE_ENTRIES_DEF = 16384;
  localparam int BUF_BYTES = 44;
  localparam int BUF_W = BUF_BYTES * 8;
  localparam int QDEPTH = 4;
  localparam int WANTED_MAX = 4;

  localparam logic [7:0] T_R = 8'h52;
  localparam logic [7:0] T_S = 8'h53;
  localparam logic [7:0] T_H = 8'h48;
  localparam logic [7:0] T_A = 8'h41;
  localparam logic [7:0] T_F = 8'h46;
  localparam logic [7:0] T_P = 8'h50;
  localparam logic [7:0] T_Q = 8'h51;
  localparam logic [7:0] T_U = 8'h55;
  localparam logic [7:0] T_C = 8'h43;
  localparam logic [7:0] T_E = 8'h45;
  localparam logic [7:0] T_X = 8'h58;
  localparam logic [7:0] T_B = 8'h42;
  localparam logic [7:0] T_D = 8'h44;

  localparam logic [2:0] REG_EMIT_SYSTEM = 3'd0;
  localparam logic [2:0] REG_ROW_LIMIT = 3'd1;
  localparam logic [2:0] REG_WANTED_COUNT = 3'd2;
  localparam logic [2:0] REG_WANTED_0 = 3'd3;
  localparam logic [2:0] REG_WANTED_1 = 3'd4;
  localparam logic [2:0] REG_WANTED_2 = 3'd5;
  localparam logic [2:0] REG_WANTED_3 = 3'd6;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } in_t;

  typedef struct packed {
    logic [31:0] row_seq;
    logic [7:0]  msg_type;
    logic [47:0] timestamp;
    logic [63:0] symbol;
    logic [63:0] order_id;
    logic [7:0]  indicator;
    logic [63:0] shares;
    logic [31:0] price;
    logic [63:0] repl_order_id;
    logic [63:0] match_id;
    logic [31:0] attribution;
    logic        status;
  } out_t;

  // One finished message; byte 0 sits in the top bits.
  typedef struct packed {
    logic             trunc;
    logic [BUF_W-1:0] bytes;
  } msg_t;

  typedef struct packed {
    logic        emit_system;
    logic [31:0] row_limit;
    logic [2:0]  wanted_count;
    logic [63:0] wanted_0;
    logic [63:0] wanted_1;
    logic [63:0] wanted_2;
    logic [63:0] wanted_3;
  } cfg_t;

  function automatic logic [7:0] be1(input logic [BUF_W-1:0] v, input int at);
    return v[BUF_W-8*(at+1) +: 8];
  endfunction

  function automatic logic [15:0] be2(input logic [BUF_W-1:0] v, input int at);
    return v[BUF_W-8*(at+2) +: 16];
  endfunction

  function automatic logic [31:0] be4(input logic [BUF_W-1:0] v, input int at);
    return v[BUF_W-8*(at+4) +: 32];
  endfunction

  function automatic logic [47:0] be6(input logic [BUF_W-1:0] v, input int at);
    return v[BUF_W-8*(at+6) +: 48];
  endfunction

  function automatic logic [63:0] be8(input logic [BUF_W-1:0] v, input int at);
    return v[BUF_W-8*(at+8) +: 64];
  endfunction

endpackage

// File: sv/imsd_framer.sv
// Front end: length-prefix deframer and message byte capture.
// Depends on imsd_pkg.
module imsd_framer (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  imsd_pkg::in_t       in_data,
  output logic                push,
  output imsd_pkg::msg_t      push_msg
);

  localparam int BIW = $clog2(imsd_pkg::BUF_BYTES);

  typedef enum logic [3:0] {
    PH_LEN_HI = 4'b0001,
    PH_LEN_LO = 4'b0010,
    PH_BODY   = 4'b0100,
    PH_STOP   = 4'b1000
  } phase_t;

  phase_t      phase, phase_next;
  logic [15:0] msg_length, msg_length_next;
  logic [15:0] byte_count, byte_count_next;
  logic [15:0] cnt_inc;
  logic [7:0]  mbuf [imsd_pkg::BUF_BYTES];
  logic [7:0]  mbuf_next [imsd_pkg::BUF_BYTES];
  logic [7:0]  b;

  assign b = in_data.data_byte;
  assign cnt_inc = byte_count + 16'd1;

  always_comb begin
    phase_next = phase;
    msg_length_next = msg_length;
    byte_count_next = byte_count;
    mbuf_next = mbuf;
    push = 1'b0;
    push_msg.trunc = 1'b0;
    if (accept) begin
      unique case (phase)
        PH_LEN_HI: begin
          msg_length_next = {b, 8'h00};
          phase_next = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          msg_length_next = {msg_length[15:8], b};
          byte_count_next = 16'd0;
          for (int k = 0; k < imsd_pkg::BUF_BYTES; k++) mbuf_next[k] = 8'h00;
          phase_next = ({msg_length[15:8], b} == 16'd0) ? PH_STOP : PH_BODY;
        end
        PH_BODY: begin
          if (byte_count < 16'(imsd_pkg::BUF_BYTES)) mbuf_next[byte_count[BIW-1:0]] = b;
          byte_count_next = cnt_inc;
          if (cnt_inc == msg_length) begin
            phase_next = PH_LEN_HI;
            push = 1'b1;
          end
        end
        PH_STOP: begin
          phase_next = PH_STOP;
        end
        default: phase_next = PH_STOP;
      endcase
      if (in_data.end_of_stream && phase != PH_STOP) begin
        if (phase_next == PH_BODY) begin
          push = 1'b1;
          push_msg.trunc = 1'b1;
        end
        phase_next = PH_STOP;
      end
    end
    for (int k = 0; k < imsd_pkg::BUF_BYTES; k++) begin
      push_msg.bytes[(imsd_pkg::BUF_BYTES-1-k)*8 +: 8] = mbuf_next[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_LEN_HI;
      msg_length <= 16'd0;
      byte_count <= 16'd0;
    end else begin
      phase <= phase_next;
      msg_length <= msg_length_next;
      byte_count <= byte_count_next;
    end
  end

  always_ff @(posedge clk) begin
    mbuf <= mbuf_next;
  end

endmodule

// File: sv/imsd_queue.sv
// Short message queue between the deframer and the decode back end.
// Depends on imsd_pkg.
module imsd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  imsd_pkg::msg_t push_msg,
  input  logic           pop,
  output logic           head_valid,
  output imsd_pkg::msg_t head,
  output logic           full
);

  localparam int PW = $clog2(imsd_pkg::QDEPTH);
  localparam int CW = $clog2(imsd_pkg::QDEPTH + 1);

  imsd_pkg::msg_t mem [imsd_pkg::QDEPTH];
  logic [PW-1:0]  wr_ptr, rd_ptr;
  logic [CW-1:0]  count;

  assign head_valid = count != '0;
  assign full = count == CW'(imsd_pkg::QDEPTH);
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PW'(imsd_pkg::QDEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      if (pop) rd_ptr <= (rd_ptr == PW'(imsd_pkg::QDEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      if (push && !pop) count <= count + CW'(1);
      else if (pop && !push) count <= count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_msg;
  end

endmodule

// File: sv/imsd_exec.sv
// Back end: symbol directory, filtering, field extraction, record numbering.
// Depends on imsd_pkg.
module imsd_exec #(
  parameter int LOCATE_ENTRIES = imsd_pkg::LOCATE_ENTRIES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  imsd_pkg::cfg_t cfg,
  input  logic           head_valid,
  input  imsd_pkg::msg_t head,
  output logic           pop,
  output logic           clearing,
  output logic           out_valid,
  input  logic           out_stall,
  output imsd_pkg::out_t out_data
);

  localparam int AW = $clog2(LOCATE_ENTRIES);

  logic [63:0] sym_mem [LOCATE_ENTRIES];
  logic [1:0]  flg_mem [LOCATE_ENTRIES];
  logic [63:0] sym_rd;
  logic [1:0]  flg_rd;
  logic [AW-1:0] clr_idx;
  logic [15:0] head_loc;
  logic [AW-1:0] head_addr, cur_addr, flg_addr;
  logic [1:0]  flg_wdata;
  logic        flg_we, sym_we;

  logic           busy, stopped;
  imsd_pkg::msg_t cur;
  logic [31:0]    row_count, row_count_next;

  logic [7:0]  t;
  logic [15:0] loc;
  logic        known, filtering, hit, is_r, listed, sys, emit, produce, can_go, done;
  logic        lim_hit;
  logic [2:0]  n_wanted;
  logic [63:0] rsym;
  logic [63:0] wanted [imsd_pkg::WANTED_MAX];
  imsd_pkg::out_t rec;

  assign head_loc = imsd_pkg::be2(head.bytes, 1);
  assign head_addr = head_loc[AW-1:0];
  assign pop = head_valid && !busy && !clearing;

  assign t = imsd_pkg::be1(cur.bytes, 0);
  assign loc = imsd_pkg::be2(cur.bytes, 1);
  assign cur_addr = loc[AW-1:0];
  assign known = {1'b0, loc} < 17'(LOCATE_ENTRIES);
  assign filtering = cfg.wanted_count != 3'd0;
  assign n_wanted = (cfg.wanted_count > 3'(imsd_pkg::WANTED_MAX)) ?
                    3'(imsd_pkg::WANTED_MAX) : cfg.wanted_count;
  assign rsym = imsd_pkg::be8(cur.bytes, 11);
  assign wanted[0] = cfg.wanted_0;
  assign wanted[1] = cfg.wanted_1;
  assign wanted[2] = cfg.wanted_2;
  assign wanted[3] = cfg.wanted_3;

  always_comb begin
    hit = 1'b0;
    for (int i = 0; i < imsd_pkg::WANTED_MAX; i++) begin
      if (3'(i) < n_wanted && wanted[i] == rsym) hit = 1'b1;
    end
  end

  assign is_r = t == imsd_pkg::T_R;
  assign sys = t == imsd_pkg::T_S || t == imsd_pkg::T_H;
  assign listed = t == imsd_pkg::T_A || t == imsd_pkg::T_F || t == imsd_pkg::T_E ||
                  t == imsd_pkg::T_C || t == imsd_pkg::T_X || t == imsd_pkg::T_D ||
                  t == imsd_pkg::T_U || t == imsd_pkg::T_P || t == imsd_pkg::T_Q ||
                  t == imsd_pkg::T_B || sys;
  assign emit = !cur.trunc && listed && !(sys && !cfg.emit_system) &&
                !(filtering && t != imsd_pkg::T_S && (!known || !flg_rd[0]));
  assign produce = !stopped && (cur.trunc || emit);
  assign can_go = !produce || !out_valid || !out_stall;
  assign done = busy && can_go;

  assign row_count_next = (row_count == 32'hFFFF_FFFF) ? row_count : row_count + 32'd1;
  assign lim_hit = cfg.row_limit != 32'd0 && row_count_next >= cfg.row_limit;

  assign sym_we = done && !stopped && !cur.trunc && is_r && known && !flg_rd[1];
  assign flg_we = clearing || (done && !stopped && !cur.trunc && is_r && known);
  assign flg_addr = clearing ? clr_idx : cur_addr;
  assign flg_wdata = clearing ? 2'b00 : {1'b1, filtering ? hit : flg_rd[0]};

  always_comb begin
    rec = '0;
    if (!cur.trunc) begin
      rec.row_seq = row_count_next;
      rec.msg_type = t;
      rec.timestamp = imsd_pkg::be6(cur.bytes, 5);
      priority if (t == imsd_pkg::T_A || t == imsd_pkg::T_F || t == imsd_pkg::T_P) begin
        rec.symbol = imsd_pkg::be8(cur.bytes, 24);
        rec.order_id = imsd_pkg::be8(cur.bytes, 11);
        rec.indicator = imsd_pkg::be1(cur.bytes, 19);
        rec.shares = {32'd0, imsd_pkg::be4(cur.bytes, 20)};
        rec.price = imsd_pkg::be4(cur.bytes, 32);
        if (t == imsd_pkg::T_P) rec.match_id = imsd_pkg::be8(cur.bytes, 36);
        if (t == imsd_pkg::T_F) rec.attribution = imsd_pkg::be4(cur.bytes, 36);
      end else if (t == imsd_pkg::T_Q) begin
        rec.symbol = imsd_pkg::be8(cur.bytes, 19);
        rec.shares = imsd_pkg::be8(cur.bytes, 11);
        rec.price = imsd_pkg::be4(cur.bytes, 27);
        rec.match_id = imsd_pkg::be8(cur.bytes, 31);
      end else if (t == imsd_pkg::T_H) begin
        rec.symbol = imsd_pkg::be8(cur.bytes, 11);
        rec.attribution = {24'd0, imsd_pkg::be1(cur.bytes, 19)};
      end else if (t == imsd_pkg::T_S) begin
        rec.attribution = {24'd0, imsd_pkg::be1(cur.bytes, 11)};
      end else begin
        if (known && flg_rd[1]) rec.symbol = sym_rd;
        if (t != imsd_pkg::T_B) rec.order_id = imsd_pkg::be8(cur.bytes, 11);
        if (t == imsd_pkg::T_E || t == imsd_pkg::T_C || t == imsd_pkg::T_X) begin
          rec.shares = {32'd0, imsd_pkg::be4(cur.bytes, 19)};
        end
        if (t == imsd_pkg::T_E || t == imsd_pkg::T_C) begin
          rec.match_id = imsd_pkg::be8(cur.bytes, 23);
        end
        if (t == imsd_pkg::T_C) begin
          rec.indicator = imsd_pkg::be1(cur.bytes, 31);
          rec.price = imsd_pkg::be4(cur.bytes, 32);
        end
        if (t == imsd_pkg::T_U) begin
          rec.shares = {32'd0, imsd_pkg::be4(cur.bytes, 27)};
          rec.price = imsd_pkg::be4(cur.bytes, 31);
          rec.repl_order_id = imsd_pkg::be8(cur.bytes, 19);
        end
        if (t == imsd_pkg::T_B) rec.match_id = imsd_pkg::be8(cur.bytes, 11);
      end
    end else begin
      rec.status = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) sym_rd <= sym_mem[head_addr];
    if (sym_we) sym_mem[cur_addr] <= rsym;
  end

  always_ff @(posedge clk) begin
    if (pop) flg_rd <= flg_mem[head_addr];
    if (flg_we) flg_mem[flg_addr] <= flg_wdata;
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= head;
    if (done && produce) out_data <= rec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx <= '0;
      busy <= 1'b0;
      stopped <= 1'b0;
      row_count <= 32'd0;
      out_valid <= 1'b0;
    end else begin
      if (clearing) begin
        clr_idx <= clr_idx + AW'(1);
        if (clr_idx == AW'(LOCATE_ENTRIES - 1)) clearing <= 1'b0;
      end
      if (pop) busy <= 1'b1;
      else if (done) busy <= 1'b0;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (done && produce) begin
        out_valid <= 1'b1;
        if (cur.trunc) begin
          stopped <= 1'b1;
        end else begin
          row_count <= row_count_next;
          if (lim_hit) stopped <= 1'b1;
        end
      end
    end
  end

endmodule

// File: sv/itch_message_stream_decoder_core.sv
// ITCH message stream decoder top: config registers, deframer, queue, back end.
// Depends on imsd_pkg, imsd_framer, imsd_queue, imsd_exec.
// One byte accepted per cycle unless the message queue is full or the flag table
// is being swept. Each message occupies the back end for a table read, then a
// decision. After reset the locate flag table is swept over all LOCATE_ENTRIES
// entries; no bytes are taken during the sweep, config writes are.
module itch_message_stream_decoder_core #(
  parameter int LOCATE_ENTRIES = imsd_pkg::LOCATE_ENTRIES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  imsd_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output imsd_pkg::out_t out_data,
  input  logic           cfg_write,
  input  logic [2:0]     cfg_index,
  input  logic [63:0]    cfg_data
);

  imsd_pkg::cfg_t cfg;
  imsd_pkg::msg_t push_msg, head;
  logic push, pop, head_valid, full, clearing, accept;

  assign in_stall = full || clearing;
  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= imsd_pkg::cfg_t'{emit_system: 1'b1, default: '0};
    end else if (cfg_write) begin
      unique case (cfg_index)
        imsd_pkg::REG_EMIT_SYSTEM:  cfg.emit_system <= cfg_data[0];
        imsd_pkg::REG_ROW_LIMIT:    cfg.row_limit <= cfg_data[31:0];
        imsd_pkg::REG_WANTED_COUNT: cfg.wanted_count <= cfg_data[2:0];
        imsd_pkg::REG_WANTED_0:     cfg.wanted_0 <= cfg_data;
        imsd_pkg::REG_WANTED_1:     cfg.wanted_1 <= cfg_data;
        imsd_pkg::REG_WANTED_2:     cfg.wanted_2 <= cfg_data;
        imsd_pkg::REG_WANTED_3:     cfg.wanted_3 <= cfg_data;
        default: ;
      endcase
    end
  end

  imsd_framer u_framer (
    .clk(clk), .rst(rst), .accept(accept), .in_data(in_data),
    .push(push), .push_msg(push_msg)
  );

  imsd_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_msg(push_msg), .pop(pop),
    .head_valid(head_valid), .head(head), .full(full)
  );

  imsd_exec #(.LOCATE_ENTRIES(LOCATE_ENTRIES)) u_exec (
    .clk(clk), .rst(rst), .cfg(cfg), .head_valid(head_valid), .head(head),
    .pop(pop), .clearing(clearing), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data)
  );

endmodule
